// File: hw/rtl/fsc_pkg.sv
// Shared constants, codes and arithmetic helpers for the frustum sphere cull block.
// Self-contained; used by frustum_sphere_cull.
`default_nettype none

package fsc_pkg;

  localparam int CW  = 32;
  localparam int UW  = CW - 1;
  localparam int PW  = 2 * CW;
  localparam int HW  = PW / 2;
  localparam int SW  = 2 * PW;
  localparam int CIW = 3;

  localparam logic [CIW-1:0] CFG_LEFT   = 3'd0;
  localparam logic [CIW-1:0] CFG_RIGHT  = 3'd1;
  localparam logic [CIW-1:0] CFG_TOP    = 3'd2;
  localparam logic [CIW-1:0] CFG_BOTTOM = 3'd3;
  localparam logic [CIW-1:0] CFG_NEAR   = 3'd4;
  localparam logic [CIW-1:0] CFG_FAR    = 3'd5;

  localparam logic signed [CW-1:0] RST_LEFT   = CW'(-65536);
  localparam logic signed [CW-1:0] RST_RIGHT  = CW'(65536);
  localparam logic signed [CW-1:0] RST_TOP    = CW'(65536);
  localparam logic signed [CW-1:0] RST_BOTTOM = CW'(-65536);
  localparam logic [UW-1:0]        RST_NEAR   = UW'(65536);
  localparam logic [UW-1:0]        RST_FAR    = UW'(6553600);

  localparam int NPL      = 6;
  localparam int P_NEAR   = 0;
  localparam int P_FAR    = 1;
  localparam int P_LEFT   = 2;
  localparam int P_RIGHT  = 3;
  localparam int P_TOP    = 4;
  localparam int P_BOTTOM = 5;

  localparam logic [2:0] C_LTN = 3'd0;
  localparam logic [2:0] C_LTF = 3'd1;
  localparam logic [2:0] C_LBN = 3'd2;
  localparam logic [2:0] C_LBF = 3'd3;
  localparam logic [2:0] C_RTN = 3'd4;
  localparam logic [2:0] C_RTF = 3'd5;
  localparam logic [2:0] C_RBN = 3'd6;
  localparam logic [2:0] C_RBF = 3'd7;

  localparam int CB_FAR    = 0;
  localparam int CB_BOTTOM = 1;
  localparam int CB_RIGHT  = 2;

  localparam logic [1:0] DROP_X    = 2'd0;
  localparam logic [1:0] DROP_Y    = 2'd1;
  localparam logic [1:0] DROP_NONE = 2'd3;

  function automatic logic signed [PW+1:0] smul(input logic signed [CW:0] a,
                                                input logic signed [CW:0] b);
    return a * b;
  endfunction

  function automatic logic [PW-1:0] umul(input logic [HW-1:0] a, input logic [HW-1:0] b);
    return a * b;
  endfunction

  function automatic logic signed [CW:0] sxt(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic signed [CW:0] uxt(input logic [UW-1:0] v);
    return {2'b00, v};
  endfunction

  function automatic logic [PW-1:0] mag(input logic [PW-1:0] v);
    return v[PW-1] ? (~v + PW'(1)) : v;
  endfunction

  function automatic logic [SW-1:0] prod_sum(input logic [PW-1:0] hh, input logic [PW-1:0] hl,
                                             input logic [PW-1:0] lh, input logic [PW-1:0] ll);
    return {hh, {PW{1'b0}}} + {{HW{1'b0}}, hl, {HW{1'b0}}}
         + {{HW{1'b0}}, lh, {HW{1'b0}}} + {{PW{1'b0}}, ll};
  endfunction

  function automatic logic [SW-1:0] sq_sum(input logic [PW-1:0] hh, input logic [PW-1:0] hl,
                                           input logic [PW-1:0] ll);
    return {hh, {PW{1'b0}}} + {{(HW-1){1'b0}}, hl, {(HW+1){1'b0}}} + {{PW{1'b0}}, ll};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/frustum_sphere_cull.sv
// Top level of the frustum sphere cull block: configuration registers, derived
// frustum tables and the seven-stage test pipeline. Depends on fsc_pkg.
//
// The block takes one sphere word per cycle while in_stall is low and returns one touches bit
// per word, in order. After the input register come plane products, plane distances, square
// partial products, wide sums, plane rejection and the final compare, each in a register
// stage. Bubbles are squeezed out under stall, so a word is accepted while a finished result
// waits. Plane, corner and edge constants are rederived from the registers through two
// register stages after a write, which completes before any sphere accepted after the write
// reaches them.
`default_nettype none

module frustum_sphere_cull (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fsc_pkg::CIW-1:0]       cfg_index,
  input  wire logic [fsc_pkg::CW-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [fsc_pkg::CW-1:0] in_center_x,
  input  wire logic signed [fsc_pkg::CW-1:0] in_center_y,
  input  wire logic signed [fsc_pkg::CW-1:0] in_center_z,
  input  wire logic [fsc_pkg::UW-1:0]        in_radius,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_touches
);

  localparam int CW  = fsc_pkg::CW;
  localparam int UW  = fsc_pkg::UW;
  localparam int PW  = fsc_pkg::PW;
  localparam int HW  = fsc_pkg::HW;
  localparam int SW  = fsc_pkg::SW;
  localparam int NPL = fsc_pkg::NPL;

  logic signed [CW-1:0] win_l_r, win_r_r, win_t_r, win_b_r;
  logic [UW-1:0]        near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= fsc_pkg::RST_LEFT;
      win_r_r <= fsc_pkg::RST_RIGHT;
      win_t_r <= fsc_pkg::RST_TOP;
      win_b_r <= fsc_pkg::RST_BOTTOM;
      near_r  <= fsc_pkg::RST_NEAR;
      far_r   <= fsc_pkg::RST_FAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsc_pkg::CFG_LEFT:   win_l_r <= cfg_data;
        fsc_pkg::CFG_RIGHT:  win_r_r <= cfg_data;
        fsc_pkg::CFG_TOP:    win_t_r <= cfg_data;
        fsc_pkg::CFG_BOTTOM: win_b_r <= cfg_data;
        fsc_pkg::CFG_NEAR:   near_r  <= cfg_data[UW-1:0];
        fsc_pkg::CFG_FAR:    far_r   <= cfg_data[UW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW:0] n33, f33, l33, r33, t33, b33;
  assign n33 = fsc_pkg::uxt(near_r);
  assign f33 = fsc_pkg::uxt(far_r);
  assign l33 = fsc_pkg::sxt(win_l_r);
  assign r33 = fsc_pkg::sxt(win_r_r);
  assign t33 = fsc_pkg::sxt(win_t_r);
  assign b33 = fsc_pkg::sxt(win_b_r);

  // First derivation stage: products of the window registers.
  logic [PW-1:0] dk_nl_r, dk_nr_r, dk_nt_r, dk_nb_r, dk_fl_r, dk_fr_r, dk_ft_r, dk_fb_r;
  logic [PW-1:0] dk_nn_r, dk_fn_r, dk_ll_r, dk_rr_r, dk_tt_r, dk_bb_r;

  always_ff @(posedge clk) begin
    dk_nl_r <= PW'(fsc_pkg::smul(n33, l33));
    dk_nr_r <= PW'(fsc_pkg::smul(n33, r33));
    dk_nt_r <= PW'(fsc_pkg::smul(n33, t33));
    dk_nb_r <= PW'(fsc_pkg::smul(n33, b33));
    dk_fl_r <= PW'(fsc_pkg::smul(f33, l33));
    dk_fr_r <= PW'(fsc_pkg::smul(f33, r33));
    dk_ft_r <= PW'(fsc_pkg::smul(f33, t33));
    dk_fb_r <= PW'(fsc_pkg::smul(f33, b33));
    dk_nn_r <= PW'(fsc_pkg::smul(n33, n33));
    dk_fn_r <= PW'(fsc_pkg::smul(f33, n33));
    dk_ll_r <= PW'(fsc_pkg::smul(l33, l33));
    dk_rr_r <= PW'(fsc_pkg::smul(r33, r33));
    dk_tt_r <= PW'(fsc_pkg::smul(t33, t33));
    dk_bb_r <= PW'(fsc_pkg::smul(b33, b33));
  end

  // Second derivation stage: plane norms, edge direction lengths and corners.
  logic [PW-1:0] norm2_r [NPL];
  logic [PW-1:0] dn2_r [4];
  logic [PW-1:0] kx_r [8];
  logic [PW-1:0] ky_r [8];
  logic [PW-1:0] kz_r [8];

  always_ff @(posedge clk) begin
    norm2_r[fsc_pkg::P_NEAR]   <= PW'(1);
    norm2_r[fsc_pkg::P_FAR]    <= PW'(1);
    norm2_r[fsc_pkg::P_LEFT]   <= dk_nn_r + dk_ll_r;
    norm2_r[fsc_pkg::P_RIGHT]  <= dk_nn_r + dk_rr_r;
    norm2_r[fsc_pkg::P_TOP]    <= dk_nn_r + dk_tt_r;
    norm2_r[fsc_pkg::P_BOTTOM] <= dk_nn_r + dk_bb_r;
    dn2_r[0] <= dk_ll_r + dk_tt_r + dk_nn_r;
    dn2_r[1] <= dk_ll_r + dk_bb_r + dk_nn_r;
    dn2_r[2] <= dk_rr_r + dk_tt_r + dk_nn_r;
    dn2_r[3] <= dk_rr_r + dk_bb_r + dk_nn_r;
    kx_r[fsc_pkg::C_LTN] <= dk_nl_r;
    kx_r[fsc_pkg::C_LTF] <= dk_fl_r;
    kx_r[fsc_pkg::C_LBN] <= dk_nl_r;
    kx_r[fsc_pkg::C_LBF] <= dk_fl_r;
    kx_r[fsc_pkg::C_RTN] <= dk_nr_r;
    kx_r[fsc_pkg::C_RTF] <= dk_fr_r;
    kx_r[fsc_pkg::C_RBN] <= dk_nr_r;
    kx_r[fsc_pkg::C_RBF] <= dk_fr_r;
    ky_r[fsc_pkg::C_LTN] <= dk_nt_r;
    ky_r[fsc_pkg::C_LTF] <= dk_ft_r;
    ky_r[fsc_pkg::C_LBN] <= dk_nb_r;
    ky_r[fsc_pkg::C_LBF] <= dk_fb_r;
    ky_r[fsc_pkg::C_RTN] <= dk_nt_r;
    ky_r[fsc_pkg::C_RTF] <= dk_ft_r;
    ky_r[fsc_pkg::C_RBN] <= dk_nb_r;
    ky_r[fsc_pkg::C_RBF] <= dk_fb_r;
    kz_r[fsc_pkg::C_LTN] <= ~dk_nn_r + PW'(1);
    kz_r[fsc_pkg::C_LTF] <= ~dk_fn_r + PW'(1);
    kz_r[fsc_pkg::C_LBN] <= ~dk_nn_r + PW'(1);
    kz_r[fsc_pkg::C_LBF] <= ~dk_fn_r + PW'(1);
    kz_r[fsc_pkg::C_RTN] <= ~dk_nn_r + PW'(1);
    kz_r[fsc_pkg::C_RTF] <= ~dk_fn_r + PW'(1);
    kz_r[fsc_pkg::C_RBN] <= ~dk_nn_r + PW'(1);
    kz_r[fsc_pkg::C_RBF] <= ~dk_fn_r + PW'(1);
  end

  // Handshake: each stage advances when it is empty or the next one advances.
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_r || !out_stall;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign in_stall  = !rdy0;
  assign out_valid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // Stage 0: input word.
  logic signed [CW-1:0] s0_x_r, s0_y_r, s0_z_r;
  logic [UW-1:0]        s0_rad_r;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_x_r   <= in_center_x;
      s0_y_r   <= in_center_y;
      s0_z_r   <= in_center_z;
      s0_rad_r <= in_radius;
    end
  end

  // Stage 1: products of the center with the window, and of the radius.
  logic signed [CW:0] x33, y33, z33, rad33;
  assign x33   = fsc_pkg::sxt(s0_x_r);
  assign y33   = fsc_pkg::sxt(s0_y_r);
  assign z33   = fsc_pkg::sxt(s0_z_r);
  assign rad33 = fsc_pkg::uxt(s0_rad_r);

  logic [PW-1:0] s1_nx_r, s1_ny_r, s1_nz_r, s1_lz_r, s1_rz_r, s1_tz_r, s1_bz_r;
  logic [PW-1:0] s1_xt_r, s1_xb_r, s1_yl_r, s1_yr_r, s1_rr_r, s1_nr_r;
  logic signed [CW-1:0] s1_z_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_nx_r <= PW'(fsc_pkg::smul(n33, x33));
      s1_ny_r <= PW'(fsc_pkg::smul(n33, y33));
      s1_nz_r <= PW'(fsc_pkg::smul(n33, z33));
      s1_lz_r <= PW'(fsc_pkg::smul(l33, z33));
      s1_rz_r <= PW'(fsc_pkg::smul(r33, z33));
      s1_tz_r <= PW'(fsc_pkg::smul(t33, z33));
      s1_bz_r <= PW'(fsc_pkg::smul(b33, z33));
      s1_xt_r <= PW'(fsc_pkg::smul(x33, t33));
      s1_xb_r <= PW'(fsc_pkg::smul(x33, b33));
      s1_yl_r <= PW'(fsc_pkg::smul(y33, l33));
      s1_yr_r <= PW'(fsc_pkg::smul(y33, r33));
      s1_rr_r <= PW'(fsc_pkg::smul(rad33, rad33));
      s1_nr_r <= PW'(fsc_pkg::smul(n33, rad33));
      s1_z_r  <= s0_z_r;
    end
  end

  // Stage 2: signed plane distances, flipped laterally when the center is behind the eye.
  logic [PW-1:0] zz64, n64, f64;
  logic [PW-1:0] dist_nxt [NPL];
  logic [NPL-1:0] out_nxt;
  logic           flip;

  assign zz64 = {{CW{s1_z_r[CW-1]}}, s1_z_r};
  assign n64  = {{(PW-UW){1'b0}}, near_r};
  assign f64  = {{(PW-UW){1'b0}}, far_r};
  assign flip = !s1_z_r[CW-1] && (s1_z_r != '0);

  always_comb begin
    dist_nxt[fsc_pkg::P_NEAR]   = zz64 + n64;
    dist_nxt[fsc_pkg::P_FAR]    = ~zz64 + PW'(1) - f64;
    dist_nxt[fsc_pkg::P_LEFT]   = ~s1_nx_r + PW'(1) - s1_lz_r;
    dist_nxt[fsc_pkg::P_RIGHT]  = s1_nx_r + s1_rz_r;
    dist_nxt[fsc_pkg::P_TOP]    = s1_ny_r + s1_tz_r;
    dist_nxt[fsc_pkg::P_BOTTOM] = ~s1_ny_r + PW'(1) - s1_bz_r;
    if (flip) begin
      for (int i = fsc_pkg::P_LEFT; i < NPL; i++) begin
        dist_nxt[i] = ~dist_nxt[i] + PW'(1);
      end
    end
    for (int i = 0; i < NPL; i++) begin
      out_nxt[i] = !dist_nxt[i][PW-1] && (dist_nxt[i] != '0);
    end
  end

  logic [PW-1:0]  s2_dist_r [NPL];
  logic [NPL-1:0] s2_out_r;
  logic [PW-1:0]  s2_nx_r, s2_ny_r, s2_nz_r, s2_lz_r, s2_rz_r, s2_tz_r, s2_bz_r;
  logic [PW-1:0]  s2_xt_r, s2_xb_r, s2_yl_r, s2_yr_r, s2_rr_r, s2_nr_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < NPL; i++) begin
        s2_dist_r[i] <= dist_nxt[i];
      end
      s2_out_r <= out_nxt;
      s2_nx_r  <= s1_nx_r;
      s2_ny_r  <= s1_ny_r;
      s2_nz_r  <= s1_nz_r;
      s2_lz_r  <= s1_lz_r;
      s2_rz_r  <= s1_rz_r;
      s2_tz_r  <= s1_tz_r;
      s2_bz_r  <= s1_bz_r;
      s2_xt_r  <= s1_xt_r;
      s2_xb_r  <= s1_xb_r;
      s2_yl_r  <= s1_yl_r;
      s2_yr_r  <= s1_yr_r;
      s2_rr_r  <= s1_rr_r;
      s2_nr_r  <= s1_nr_r;
    end
  end

  // Stage 3: edge or corner selection and vector terms; partial products of plane tests.
  logic [2:0]    cnt;
  logic [2:0]    sel_c;
  logic          sel_ray;
  logic [1:0]    sel_drop;
  logic          is_left, is_top;
  logic [PW-1:0] vc_nxt [3];
  logic [PW-1:0] ra_nxt, rb_nxt;
  logic          need_nxt;
  logic          o_l, o_r, o_t, o_b, o_n;

  assign o_n = s2_out_r[fsc_pkg::P_NEAR];
  assign o_l = s2_out_r[fsc_pkg::P_LEFT];
  assign o_r = s2_out_r[fsc_pkg::P_RIGHT];
  assign o_t = s2_out_r[fsc_pkg::P_TOP];
  assign o_b = s2_out_r[fsc_pkg::P_BOTTOM];
  assign cnt = 3'($countones(s2_out_r));
  assign need_nxt = (cnt == 3'd2) || (cnt == 3'd3);

  always_comb begin
    sel_c    = fsc_pkg::C_LTN;
    sel_ray  = 1'b0;
    sel_drop = fsc_pkg::DROP_NONE;
    if (cnt == 3'd3) begin
      sel_c = {!o_l, !o_t, !o_n};
    end else priority if (o_l) begin
      priority if (o_t) begin
        sel_c = fsc_pkg::C_LTN; sel_ray = 1'b1;
      end else if (o_b) begin
        sel_c = fsc_pkg::C_LBN; sel_ray = 1'b1;
      end else if (o_n) begin
        sel_c = fsc_pkg::C_LTN; sel_drop = fsc_pkg::DROP_Y;
      end else begin
        sel_c = fsc_pkg::C_LTF; sel_drop = fsc_pkg::DROP_Y;
      end
    end else if (o_r) begin
      priority if (o_t) begin
        sel_c = fsc_pkg::C_RTN; sel_ray = 1'b1;
      end else if (o_b) begin
        sel_c = fsc_pkg::C_RBN; sel_ray = 1'b1;
      end else if (o_n) begin
        sel_c = fsc_pkg::C_RTN; sel_drop = fsc_pkg::DROP_Y;
      end else begin
        sel_c = fsc_pkg::C_RTF; sel_drop = fsc_pkg::DROP_Y;
      end
    end else if (o_n) begin
      sel_c    = o_t ? fsc_pkg::C_LTN : fsc_pkg::C_LBN;
      sel_drop = fsc_pkg::DROP_X;
    end else begin
      sel_c    = o_t ? fsc_pkg::C_LTF : fsc_pkg::C_LBF;
      sel_drop = fsc_pkg::DROP_X;
    end
  end

  assign is_left = !sel_c[fsc_pkg::CB_RIGHT];
  assign is_top  = !sel_c[fsc_pkg::CB_BOTTOM];

  always_comb begin
    if (sel_ray) begin
      vc_nxt[0] = ~s2_ny_r + PW'(1) - (is_top ? s2_tz_r : s2_bz_r);
      vc_nxt[1] = (is_left ? s2_lz_r : s2_rz_r) + s2_nx_r;
      vc_nxt[2] = (is_top ? s2_xt_r : s2_xb_r) - (is_left ? s2_yl_r : s2_yr_r);
      ra_nxt    = s2_rr_r;
      rb_nxt    = dn2_r[{sel_c[fsc_pkg::CB_RIGHT], sel_c[fsc_pkg::CB_BOTTOM]}];
    end else begin
      vc_nxt[0] = s2_nx_r - kx_r[sel_c];
      vc_nxt[1] = s2_ny_r - ky_r[sel_c];
      vc_nxt[2] = s2_nz_r - kz_r[sel_c];
      if (sel_drop == fsc_pkg::DROP_X) vc_nxt[0] = '0;
      if (sel_drop == fsc_pkg::DROP_Y) vc_nxt[1] = '0;
      ra_nxt    = s2_nr_r;
      rb_nxt    = s2_nr_r;
    end
  end

  logic [PW-1:0]  s3_vm_r [3];
  logic [PW-1:0]  s3_ra_r, s3_rb_r;
  logic           s3_need_r;
  logic [NPL-1:0] s3_out_r;
  logic [PW-1:0]  s3_bhh_r [NPL];
  logic [PW-1:0]  s3_bhl_r [NPL];
  logic [PW-1:0]  s3_bll_r [NPL];
  logic [PW-1:0]  s3_phh_r [NPL];
  logic [PW-1:0]  s3_phl_r [NPL];
  logic [PW-1:0]  s3_plh_r [NPL];
  logic [PW-1:0]  s3_pll_r [NPL];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int j = 0; j < 3; j++) begin
        s3_vm_r[j] <= fsc_pkg::mag(vc_nxt[j]);
      end
      s3_ra_r   <= ra_nxt;
      s3_rb_r   <= rb_nxt;
      s3_need_r <= need_nxt;
      s3_out_r  <= s2_out_r;
      for (int i = 0; i < NPL; i++) begin
        s3_bhh_r[i] <= fsc_pkg::umul(s2_dist_r[i][PW-1:HW], s2_dist_r[i][PW-1:HW]);
        s3_bhl_r[i] <= fsc_pkg::umul(s2_dist_r[i][PW-1:HW], s2_dist_r[i][HW-1:0]);
        s3_bll_r[i] <= fsc_pkg::umul(s2_dist_r[i][HW-1:0], s2_dist_r[i][HW-1:0]);
        s3_phh_r[i] <= fsc_pkg::umul(s2_rr_r[PW-1:HW], norm2_r[i][PW-1:HW]);
        s3_phl_r[i] <= fsc_pkg::umul(s2_rr_r[PW-1:HW], norm2_r[i][HW-1:0]);
        s3_plh_r[i] <= fsc_pkg::umul(s2_rr_r[HW-1:0], norm2_r[i][PW-1:HW]);
        s3_pll_r[i] <= fsc_pkg::umul(s2_rr_r[HW-1:0], norm2_r[i][HW-1:0]);
      end
    end
  end

  // Stage 4: wide plane sums; partial products of the edge or corner test.
  logic [SW-1:0]  s4_sq_r [NPL];
  logic [SW-1:0]  s4_pr_r [NPL];
  logic [NPL-1:0] s4_out_r;
  logic           s4_need_r;
  logic [PW-1:0]  s4_ehh_r [3];
  logic [PW-1:0]  s4_ehl_r [3];
  logic [PW-1:0]  s4_ell_r [3];
  logic [PW-1:0]  s4_rhh_r, s4_rhl_r, s4_rlh_r, s4_rll_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < NPL; i++) begin
        s4_sq_r[i] <= fsc_pkg::sq_sum(s3_bhh_r[i], s3_bhl_r[i], s3_bll_r[i]);
        s4_pr_r[i] <= fsc_pkg::prod_sum(s3_phh_r[i], s3_phl_r[i], s3_plh_r[i], s3_pll_r[i]);
      end
      s4_out_r  <= s3_out_r;
      s4_need_r <= s3_need_r;
      for (int j = 0; j < 3; j++) begin
        s4_ehh_r[j] <= fsc_pkg::umul(s3_vm_r[j][PW-1:HW], s3_vm_r[j][PW-1:HW]);
        s4_ehl_r[j] <= fsc_pkg::umul(s3_vm_r[j][PW-1:HW], s3_vm_r[j][HW-1:0]);
        s4_ell_r[j] <= fsc_pkg::umul(s3_vm_r[j][HW-1:0], s3_vm_r[j][HW-1:0]);
      end
      s4_rhh_r <= fsc_pkg::umul(s3_ra_r[PW-1:HW], s3_rb_r[PW-1:HW]);
      s4_rhl_r <= fsc_pkg::umul(s3_ra_r[PW-1:HW], s3_rb_r[HW-1:0]);
      s4_rlh_r <= fsc_pkg::umul(s3_ra_r[HW-1:0], s3_rb_r[PW-1:HW]);
      s4_rll_r <= fsc_pkg::umul(s3_ra_r[HW-1:0], s3_rb_r[HW-1:0]);
    end
  end

  // Stage 5: plane rejection; squared terms of the edge or corner test.
  logic [NPL-1:0] beyond;

  always_comb begin
    for (int i = 0; i < NPL; i++) begin
      beyond[i] = s4_out_r[i] && (s4_pr_r[i] < s4_sq_r[i]);
    end
  end

  logic          s5_rej_r, s5_need_r;
  logic [SW-1:0] s5_sqm_r [3];
  logic [SW-1:0] s5_rhs_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_rej_r  <= |beyond;
      s5_need_r <= s4_need_r;
      for (int j = 0; j < 3; j++) begin
        s5_sqm_r[j] <= fsc_pkg::sq_sum(s4_ehh_r[j], s4_ehl_r[j], s4_ell_r[j]);
      end
      s5_rhs_r <= fsc_pkg::prod_sum(s4_rhh_r, s4_rhl_r, s4_rlh_r, s4_rll_r);
    end
  end

  // Stage 6: final compare into the output register.
  logic [SW-1:0] lhs;
  logic          touch_nxt;
  logic          out_touches_r;

  assign lhs       = s5_sqm_r[0] + s5_sqm_r[1] + s5_sqm_r[2];
  assign touch_nxt = !s5_rej_r && (!s5_need_r || (lhs < s5_rhs_r));

  always_ff @(posedge clk) begin
    if (rdy6) out_touches_r <= touch_nxt;
  end

  assign out_touches = out_touches_r;

endmodule

`default_nettype wire
